// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the reformatter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, expr, msg)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- rtl/jsr_pkg.sv -----
// Shared types and character constants of the JSON stream reformatter.
`timescale 1ns / 1ps
package jsr_pkg;

   localparam int LIT_MAX = 6;
   localparam int SPACE_W = 6;

   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_SP     = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_U      = 8'h75;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;

   localparam logic [15:0] SUR_HIGH_MIN = 16'hD800;
   localparam logic [15:0] SUR_HIGH_MAX = 16'hDBFF;
   localparam logic [20:0] SUPP_BASE    = 21'h10000;

   // One output run: literal bytes and an optional line break with indentation.
   // When brk is set the run holds exactly one literal byte.
   typedef struct packed {
      logic [LIT_MAX-1:0][7:0] lits;
      logic [2:0]              n_lit;
      logic                    brk;
      logic                    brk_first;
      logic [SPACE_W-1:0]      spaces;
   } cmd_type;

endpackage

// ----- rtl/json_stream_reformatter.sv -----
// Top level of the JSON stream reformatter: lexer front end, run queue, byte generator.
`timescale 1ns / 1ps
// The reformatter takes JSON text one word (byte) per cycle on the req_ channel and
// gives the pretty-printed or minified text on the rsp_ channel, one word per cycle
// while rsp_stall is low, with rsp_last_of_run marking the final word caused by each
// input word. Whitespace outside strings and the prefix bytes of escapes cause no
// output word at all. The input side takes one word every cycle as long as the run
// queue (QUEUE_DEPTH entries) has room; the front end classifies each word in the
// cycle it arrives and queues a run command. The output side turns one queued run
// into its words at one word per cycle when not stalled, so a run gives between 1
// and 2 + INDENT_CAP_LEVELS * SPACES_PER_LEVEL words (64 at the defaults, for a line
// break at full indentation); runs longer than one word, the indentation bursts and
// the escape and UTF-8 sequences, set the output time, and req_stall rises only when
// they have filled the queue. A run's first word passes the run queue and then the
// output register before rsp_valid shows it. A word with req_start_of_document set
// clears all lexer state before it is handled; the compact-mode register, written
// through csr_write_enable and csr_compact_mode, is left alone by it; write it only
// while the block is idle; the block does not enforce this. There is no clearing
// pass after reset. Input is assumed to be valid JSON and is not checked.
module json_stream_reformatter #(
   parameter int INDENT_CAP_LEVELS = 31,
   parameter int SPACES_PER_LEVEL  = 2,
   parameter int QUEUE_DEPTH       = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_start_of_document,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run,
   input  logic       csr_write_enable,
   input  logic       csr_compact_mode
);
   import jsr_pkg::*;

   logic    accept;
   logic    push;
   logic    pop;
   logic    q_valid;
   logic    q_full;
   cmd_type push_cmd;
   cmd_type head_cmd;

   // A word is taken whenever the queue can hold the run it may produce.
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   jsr_front #(
      .INDENT_CAP_LEVELS (INDENT_CAP_LEVELS),
      .SPACES_PER_LEVEL  (SPACES_PER_LEVEL)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_compact_mode  (csr_compact_mode),
      .accept            (accept),
      .in_byte           (req_in_byte),
      .start_of_document (req_start_of_document),
      .push              (push),
      .cmd               (push_cmd)
   );

   jsr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .pop       (pop),
      .head      (head_cmd),
      .not_empty (q_valid),
      .full      (q_full)
   );

   jsr_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head_cmd),
      .head_valid      (q_valid),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// ----- rtl/jsr_front.sv -----
// Lexer front end: classifies each input word and builds its output run command.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module jsr_front #(
   parameter int INDENT_CAP_LEVELS = 31,
   parameter int SPACES_PER_LEVEL  = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic             csr_compact_mode,
   input  logic             accept,
   input  logic [7:0]       in_byte,
   input  logic             start_of_document,
   output logic             push,
   output jsr_pkg::cmd_type cmd
);
   import jsr_pkg::*;

   typedef enum logic [6:0] {
      MODE_OUT     = 7'b0000001,
      MODE_STR     = 7'b0000010,
      MODE_ESC     = 7'b0000100,
      MODE_HEX     = 7'b0001000,
      MODE_SUR_BS  = 7'b0010000,
      MODE_SUR_U   = 7'b0100000,
      MODE_LOW_HEX = 7'b1000000
   } mode_type;

   mode_type    mode_ff, mode_in, cur_mode;
   logic [7:0]  depth_ff, depth_in, cur_depth, dec_depth, brk_depth, level;
   logic        pend_ff, pend_in, cur_pend;
   logic [1:0]  cnt_ff, cnt_in, cur_cnt;
   logic [15:0] acc_ff, acc_in, cur_acc, acc_new;
   logic [9:0]  hi_ff, hi_in, cur_hi;
   logic        compact_ff;
   logic        is_ws, is_open, is_close, brk_req, brk_first;
   logic [3:0]  hex_val;
   cmd_type     run;

   function automatic logic [7:0] hex_char(input logic [3:0] d);
      if (d < 4'd10) return CH_ZERO + {4'b0, d};
      return CH_UPPER_A + {4'b0, d} - 8'd10;
   endfunction

   // UTF-8 encoding of one code point, with JSON re-escaping of the specials.
   function automatic cmd_type emit_code(input logic [20:0] code);
      cmd_type r;
      r = '0;
      if (code == 21'(CH_QUOTE)) begin
         r.lits[0] = CH_BSLASH;
         r.lits[1] = CH_QUOTE;
         r.n_lit   = 3'd2;
      end else if (code == 21'(CH_BSLASH)) begin
         r.lits[0] = CH_BSLASH;
         r.lits[1] = CH_BSLASH;
         r.n_lit   = 3'd2;
      end else if (code < 21'h20) begin
         r.lits[0] = CH_BSLASH;
         r.lits[1] = CH_U;
         r.lits[2] = CH_ZERO;
         r.lits[3] = CH_ZERO;
         r.lits[4] = CH_ZERO + {7'b0, code[4]};
         r.lits[5] = hex_char(code[3:0]);
         r.n_lit   = 3'd6;
      end else if (code < 21'h80) begin
         r.lits[0] = code[7:0];
         r.n_lit   = 3'd1;
      end else if (code < 21'h800) begin
         r.lits[0] = 8'hC0 | {3'b0, code[10:6]};
         r.lits[1] = 8'h80 | {2'b0, code[5:0]};
         r.n_lit   = 3'd2;
      end else if (code < SUPP_BASE) begin
         r.lits[0] = 8'hE0 | {4'b0, code[15:12]};
         r.lits[1] = 8'h80 | {2'b0, code[11:6]};
         r.lits[2] = 8'h80 | {2'b0, code[5:0]};
         r.n_lit   = 3'd3;
      end else begin
         r.lits[0] = 8'hF0 | {5'b0, code[20:18]};
         r.lits[1] = 8'h80 | {2'b0, code[17:12]};
         r.lits[2] = 8'h80 | {2'b0, code[11:6]};
         r.lits[3] = 8'h80 | {2'b0, code[5:0]};
         r.n_lit   = 3'd4;
      end
      return r;
   endfunction

   always_comb begin
      // A start-of-document word sees the reset state.
      cur_mode  = start_of_document ? MODE_OUT : mode_ff;
      cur_depth = start_of_document ? 8'd0 : depth_ff;
      cur_pend  = start_of_document ? 1'b0 : pend_ff;
      cur_cnt   = start_of_document ? 2'd0 : cnt_ff;
      cur_acc   = start_of_document ? 16'd0 : acc_ff;
      cur_hi    = start_of_document ? 10'd0 : hi_ff;

      is_ws    = (in_byte == CH_SP) || (in_byte >= 8'h09 && in_byte <= 8'h0D);
      is_open  = (in_byte == CH_LBRACE) || (in_byte == CH_LBRACK);
      is_close = (in_byte == CH_RBRACE) || (in_byte == CH_RBRACK);

      if (in_byte >= CH_ZERO && in_byte <= 8'h39) begin
         hex_val = 4'(in_byte - CH_ZERO);
      end else if (in_byte >= CH_LOWER_A && in_byte <= 8'h66) begin
         hex_val = 4'(in_byte - CH_LOWER_A + 8'd10);
      end else if (in_byte >= CH_UPPER_A && in_byte <= 8'h46) begin
         hex_val = 4'(in_byte - CH_UPPER_A + 8'd10);
      end else begin
         hex_val = 4'd0;
      end
      acc_new = {cur_acc[11:0], hex_val};

      dec_depth = (cur_depth == 8'd0) ? 8'd0 : cur_depth - 8'd1;

      mode_in   = cur_mode;
      depth_in  = cur_depth;
      pend_in   = cur_pend;
      cnt_in    = cur_cnt;
      acc_in    = cur_acc;
      hi_in     = cur_hi;
      run       = '0;
      brk_req   = 1'b0;
      brk_first = 1'b0;

      case (cur_mode)
         MODE_STR: begin
            if (in_byte == CH_BSLASH) begin
               mode_in = MODE_ESC;
            end else begin
               run.lits[0] = in_byte;
               run.n_lit   = 3'd1;
               if (in_byte == CH_QUOTE) mode_in = MODE_OUT;
            end
         end
         MODE_ESC: begin
            mode_in = MODE_STR;
            if (in_byte == CH_U) begin
               mode_in = MODE_HEX;
               cnt_in  = 2'd0;
               acc_in  = 16'd0;
            end else if (in_byte == CH_SLASH) begin
               run.lits[0] = CH_SLASH;
               run.n_lit   = 3'd1;
            end else begin
               run.lits[0] = CH_BSLASH;
               run.lits[1] = in_byte;
               run.n_lit   = 3'd2;
            end
         end
         MODE_HEX, MODE_LOW_HEX: begin
            acc_in = acc_new;
            cnt_in = cur_cnt + 2'd1;
            if (cur_cnt == 2'd3) begin
               if (cur_mode == MODE_LOW_HEX) begin
                  // Join the pair: 0x10000 + (high ten bits << 10) + low ten bits.
                  run     = emit_code(SUPP_BASE + {1'b0, cur_hi, acc_new[9:0]});
                  mode_in = MODE_STR;
               end else if (acc_new >= SUR_HIGH_MIN && acc_new <= SUR_HIGH_MAX) begin
                  hi_in   = acc_new[9:0];
                  mode_in = MODE_SUR_BS;
               end else begin
                  run     = emit_code({5'b0, acc_new});
                  mode_in = MODE_STR;
               end
            end
         end
         MODE_SUR_BS: begin
            mode_in = MODE_SUR_U;
         end
         MODE_SUR_U: begin
            mode_in = MODE_LOW_HEX;
            cnt_in  = 2'd0;
            acc_in  = 16'd0;
         end
         default: begin
            mode_in = MODE_OUT;
            if (cur_pend && is_ws) begin
               // Whitespace keeps the deferred break waiting.
            end else if (cur_pend && is_close) begin
               // Empty container: closed at once with no break.
               pend_in     = 1'b0;
               depth_in    = dec_depth;
               run.lits[0] = in_byte;
               run.n_lit   = 3'd1;
            end else begin
               pend_in = 1'b0;
               if (cur_pend && in_byte != CH_COMMA && in_byte != CH_COLON) begin
                  brk_req   = 1'b1;
                  brk_first = 1'b1;
               end
               if (is_open) begin
                  run.lits[0] = in_byte;
                  run.n_lit   = 3'd1;
                  depth_in    = (cur_depth == 8'hFF) ? cur_depth : cur_depth + 8'd1;
                  pend_in     = 1'b1;
               end else if (is_close) begin
                  run.lits[0] = in_byte;
                  run.n_lit   = 3'd1;
                  depth_in    = dec_depth;
                  brk_req     = 1'b1;
                  brk_first   = 1'b1;
               end else if (in_byte == CH_COMMA) begin
                  run.lits[0] = in_byte;
                  run.n_lit   = 3'd1;
                  brk_req     = 1'b1;
               end else if (in_byte == CH_COLON) begin
                  run.lits[0] = in_byte;
                  run.lits[1] = CH_SP;
                  run.n_lit   = compact_ff ? 3'd1 : 3'd2;
               end else if (in_byte == CH_QUOTE) begin
                  run.lits[0] = in_byte;
                  run.n_lit   = 3'd1;
                  mode_in     = MODE_STR;
               end else if (!is_ws) begin
                  run.lits[0] = in_byte;
                  run.n_lit   = 3'd1;
               end
            end
         end
      endcase

      // A closing bracket breaks at the depth it returns to.
      brk_depth = is_close ? dec_depth : cur_depth;
      level     = (brk_depth > 8'(INDENT_CAP_LEVELS)) ? 8'(INDENT_CAP_LEVELS) : brk_depth;

      cmd           = run;
      cmd.brk       = brk_req & ~compact_ff;
      cmd.brk_first = brk_first;
      cmd.spaces    = SPACE_W'(level * SPACES_PER_LEVEL);
      push          = accept && (run.n_lit != 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_OUT;
         depth_ff   <= 8'd0;
         pend_ff    <= 1'b0;
         cnt_ff     <= 2'd0;
         acc_ff     <= 16'd0;
         hi_ff      <= 10'd0;
         compact_ff <= 1'b0;
      end else begin
         if (csr_write_enable) compact_ff <= csr_compact_mode;
         if (accept) begin
            mode_ff  <= mode_in;
            depth_ff <= depth_in;
            pend_ff  <= pend_in;
            cnt_ff   <= cnt_in;
            acc_ff   <= acc_in;
            hi_ff    <= hi_in;
         end
      end
   end

   `ASSERT_IMPLIES(a_pend_outside, clock, reset, pend_ff, mode_ff == MODE_OUT, "bracket pending inside a string")

endmodule

// ----- rtl/jsr_queue.sv -----
// Short command queue between the lexer front end and the byte generator.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module jsr_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  jsr_pkg::cmd_type push_data,
   input  logic             pop,
   output jsr_pkg::cmd_type head,
   output logic             not_empty,
   output logic             full
);
   import jsr_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   assign head      = mem_ff[rd_ptr_ff];
   assign not_empty = (cnt_ff != '0);
   assign full      = (cnt_ff == CNT_W'(DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   `ASSERT_ALWAYS(a_cnt_bound, clock, reset, cnt_ff <= CNT_W'(DEPTH), "queue count out of range")
   `ASSERT_IMPLIES(a_no_overflow, clock, reset, push, !full || pop, "push into a full queue")
   `ASSERT_IMPLIES(a_no_underflow, clock, reset, pop, not_empty, "pop from an empty queue")

endmodule

// ----- rtl/jsr_back.sv -----
// Byte generator: expands queued run commands into output words.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module jsr_back (
   input  logic             clock,
   input  logic             reset,
   input  jsr_pkg::cmd_type head,
   input  logic             head_valid,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last_of_run
);
   import jsr_pkg::*;

   logic [SPACE_W-1:0] pos_ff, pos_in;
   logic [SPACE_W:0]   pos_ext, brk_end;
   logic               valid_ff, valid_in;
   logic [7:0]         byte_ff, byte_in;
   logic               last_ff, last_in;
   logic               advance, load;

   function automatic logic [7:0] lit_at(input cmd_type c, input logic [2:0] idx);
      logic [7:0] r;
      case (idx)
         3'd0:    r = c.lits[0];
         3'd1:    r = c.lits[1];
         3'd2:    r = c.lits[2];
         3'd3:    r = c.lits[3];
         3'd4:    r = c.lits[4];
         3'd5:    r = c.lits[5];
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   always_comb begin
      advance = !valid_ff || !rsp_stall;
      load    = advance && head_valid;
      pos_ext = {1'b0, pos_ff};
      brk_end = {1'b0, head.spaces} + (SPACE_W + 1)'(1);

      // Runs with a break: newline, spaces and one literal, in either order.
      if (!head.brk) begin
         byte_in = lit_at(head, pos_ff[2:0]);
         last_in = (pos_ext == (SPACE_W + 1)'(head.n_lit) - (SPACE_W + 1)'(1));
      end else if (head.brk_first) begin
         if (pos_ff == '0) begin
            byte_in = CH_LF;
         end else if (pos_ext == brk_end) begin
            byte_in = head.lits[0];
         end else begin
            byte_in = CH_SP;
         end
         last_in = (pos_ext == brk_end);
      end else begin
         if (pos_ff == '0) begin
            byte_in = head.lits[0];
         end else if (pos_ff == SPACE_W'(1)) begin
            byte_in = CH_LF;
         end else begin
            byte_in = CH_SP;
         end
         last_in = (pos_ext == brk_end);
      end

      pop      = load && last_in;
      valid_in = advance ? head_valid : valid_ff;
      if (pop) begin
         pos_in = '0;
      end else if (load) begin
         pos_in = pos_ff + SPACE_W'(1);
      end else begin
         pos_in = pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= byte_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_last_of_run = last_ff;

   `ASSERT_IMPLIES(a_run_held, clock, reset, valid_ff && !last_ff, head_valid, "run left the queue before its last word")
   `ASSERT_IMPLIES(a_pos_in_run, clock, reset, pos_ff != '0, head_valid, "run position without a queued run")

endmodule
